[src/msps_pkg.sv]
package msps_pkg;

   // Default table depth and the duration used for a step whose time is zero
   localparam int TABLE_DEPTH_DEF = 16;
   localparam logic [15:0] DEFAULT_STEP_MS = 16'd50;

   // Item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Sequencer states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // One step of the motion table
   typedef struct packed {
      logic [15:0]        time_ms;
      logic signed [11:0] left;
      logic signed [11:0] right;
      logic signed [11:0] accel;
   } entry_type;

   // One result word
   typedef struct packed {
      logic               drive_valid;
      logic signed [11:0] left_drive;
      logic signed [11:0] right_drive;
      logic               bridge_enable;
      logic               ready_led;
      logic               running;
      logic               finished;
   } rsp_type;

   // Move cur toward target by a positive increment, clamped at the target
   function automatic logic signed [11:0] slew(input logic signed [11:0] cur,
                                               input logic signed [11:0] target,
                                               input logic signed [11:0] inc);
      logic signed [12:0] sum;
      logic signed [12:0] tgt;
      logic signed [11:0] res;
      sum = 13'sd0;
      tgt = {target[11], target};
      res = cur;
      if (cur < target) begin
         sum = {cur[11], cur} + {inc[11], inc};
         res = (sum > tgt) ? target : sum[11:0];
      end else if (cur > target) begin
         sum = {cur[11], cur} - {inc[11], inc};
         res = (sum < tgt) ? target : sum[11:0];
      end
      return res;
   endfunction

endpackage

[src/msps_table.sv]
module msps_table #(
   parameter int TABLE_DEPTH = msps_pkg::TABLE_DEPTH_DEF,
   parameter int AW = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  msps_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output msps_pkg::entry_type rd_data_a,
   output msps_pkg::entry_type rd_data_b
);

   msps_pkg::entry_type mem_ff [TABLE_DEPTH];
   msps_pkg::entry_type rd_a_ff;
   msps_pkg::entry_type rd_b_ff;

   // Write one step
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read current and following step, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[src/msps_ctrl.sv]
module msps_ctrl #(
   parameter int TABLE_DEPTH = msps_pkg::TABLE_DEPTH_DEF,
   parameter int AW = 4,
   parameter int PW = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [31:0]         req_now_ms,
   input  logic [3:0]          req_step_index,
   input  logic [15:0]         req_step_time_ms,
   input  logic signed [11:0]  req_step_left,
   input  logic signed [11:0]  req_step_right,
   input  logic signed [11:0]  req_step_accel,
   input  logic [15:0]         req_step_count,
   output logic                res_valid,
   input  logic                res_ready,
   output msps_pkg::rsp_type   res,
   output logic                tbl_wr_en,
   output logic [AW-1:0]       tbl_wr_addr,
   output msps_pkg::entry_type tbl_wr_data,
   output logic                tbl_rd_en,
   output logic [AW-1:0]       tbl_rd_addr_a,
   output logic [AW-1:0]       tbl_rd_addr_b,
   input  msps_pkg::entry_type tbl_rd_data_a,
   input  msps_pkg::entry_type tbl_rd_data_b
);

   localparam int XW = (AW > 4) ? AW : 4;

   msps_pkg::state_type state_ff, state_in;
   logic                accept;
   logic                commit;

   // Captured item
   logic [1:0]          kind_ff;
   logic [31:0]         now_ff;
   logic [15:0]         count_ff;

   // Sequencer state
   logic [PW-1:0]       loaded_ff, loaded_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic [PW-1:0]       ptr_next;
   logic [31:0]         start_ff, start_in;
   logic signed [11:0]  ramp_l_ff, ramp_l_in;
   logic signed [11:0]  ramp_r_ff, ramp_r_in;
   logic                run_ff, run_in;
   logic signed [11:0]  held_l_ff, held_l_in;
   logic signed [11:0]  held_r_ff, held_r_in;
   logic                bridge_ff, bridge_in;
   logic                led_ff, led_in;
   logic                drv_valid;
   logic                fin;

   logic [XW-1:0]       idx_ext;
   logic [PW-1:0]       cnt_clamp;
   logic [15:0]         dur;
   logic [31:0]         elapsed;
   logic signed [11:0]  slew_l;
   logic signed [11:0]  slew_r;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         msps_pkg::ST_IDLE: if (req_valid) state_in = msps_pkg::ST_EXEC;
         msps_pkg::ST_EXEC: if (res_ready) state_in = msps_pkg::ST_IDLE;
         default:           state_in = msps_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         msps_pkg::ST_IDLE: req_ready = 1'b1;
         msps_pkg::ST_EXEC: res_valid = 1'b1;
         default:           ;
      endcase
   end

   assign accept = req_valid && req_ready;
   assign commit = res_valid && res_ready;

   // Table write on accept of a write item whose index lies within the table, reads on every accept
   assign idx_ext       = XW'(req_step_index);
   assign tbl_wr_en     = accept && (req_kind == msps_pkg::KIND_WRITE) &&
                          (32'(req_step_index) < TABLE_DEPTH);
   assign tbl_wr_addr   = idx_ext[AW-1:0];
   assign tbl_wr_data   = '{time_ms: req_step_time_ms, left: req_step_left,
                            right: req_step_right, accel: req_step_accel};
   assign ptr_next      = ptr_ff + 1'b1;
   assign tbl_rd_en     = accept;
   assign tbl_rd_addr_a = (req_kind == msps_pkg::KIND_START) ? '0 : ptr_ff[AW-1:0];
   assign tbl_rd_addr_b = ptr_next[AW-1:0];

   // Step arithmetic
   assign cnt_clamp = (32'(count_ff) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(count_ff);
   assign dur       = (tbl_rd_data_a.time_ms == 16'd0) ? msps_pkg::DEFAULT_STEP_MS
                                                        : tbl_rd_data_a.time_ms;
   assign elapsed   = now_ff - start_ff;
   assign slew_l    = msps_pkg::slew(ramp_l_ff, tbl_rd_data_a.left, tbl_rd_data_a.accel);
   assign slew_r    = msps_pkg::slew(ramp_r_ff, tbl_rd_data_a.right, tbl_rd_data_a.accel);

   // Update the sequencer for the captured item
   always_comb begin
      loaded_in = loaded_ff;
      ptr_in    = ptr_ff;
      start_in  = start_ff;
      ramp_l_in = ramp_l_ff;
      ramp_r_in = ramp_r_ff;
      run_in    = run_ff;
      held_l_in = held_l_ff;
      held_r_in = held_r_ff;
      bridge_in = bridge_ff;
      led_in    = led_ff;
      drv_valid = 1'b0;
      fin       = 1'b0;
      case (kind_ff)
         msps_pkg::KIND_START: begin
            loaded_in = cnt_clamp;
            if (cnt_clamp != '0) begin
               bridge_in = 1'b1;
               led_in    = 1'b0;
               ptr_in    = '0;
               start_in  = now_ff;
               run_in    = 1'b1;
               ramp_l_in = '0;
               ramp_r_in = '0;
               if (tbl_rd_data_a.accel <= 12'sd0) begin
                  held_l_in = tbl_rd_data_a.left;
                  held_r_in = tbl_rd_data_a.right;
               end else begin
                  held_l_in = '0;
                  held_r_in = '0;
               end
               drv_valid = 1'b1;
            end
         end
         msps_pkg::KIND_TICK: begin
            if (run_ff) begin
               if (ptr_ff < loaded_ff) begin
                  // slew toward the current targets
                  if (tbl_rd_data_a.accel > 12'sd0) begin
                     ramp_l_in = slew_l;
                     ramp_r_in = slew_r;
                     held_l_in = slew_l;
                     held_r_in = slew_r;
                     drv_valid = 1'b1;
                  end
                  // advance once the step time has elapsed
                  if (elapsed >= 32'(dur)) begin
                     ptr_in    = ptr_next;
                     ramp_l_in = '0;
                     ramp_r_in = '0;
                     if (ptr_next < loaded_ff) begin
                        start_in = now_ff;
                        if (tbl_rd_data_b.accel <= 12'sd0) begin
                           held_l_in = tbl_rd_data_b.left;
                           held_r_in = tbl_rd_data_b.right;
                           drv_valid = 1'b1;
                        end
                     end else begin
                        held_l_in = '0;
                        held_r_in = '0;
                        bridge_in = 1'b0;
                        led_in    = 1'b1;
                        run_in    = 1'b0;
                        drv_valid = 1'b1;
                        fin       = 1'b1;
                     end
                  end
               end else begin
                  held_l_in = '0;
                  held_r_in = '0;
                  ramp_l_in = '0;
                  ramp_r_in = '0;
                  bridge_in = 1'b0;
                  led_in    = 1'b1;
                  run_in    = 1'b0;
                  drv_valid = 1'b1;
                  fin       = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   assign res = '{drive_valid: drv_valid, left_drive: held_l_in, right_drive: held_r_in,
                  bridge_enable: bridge_in, ready_led: led_in, running: run_in,
                  finished: fin};

   // Capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         now_ff   <= req_now_ms;
         count_ff <= req_step_count;
      end
   end

   // Control and held state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= msps_pkg::ST_IDLE;
         loaded_ff <= '0;
         ptr_ff    <= '0;
         start_ff  <= '0;
         ramp_l_ff <= '0;
         ramp_r_ff <= '0;
         run_ff    <= 1'b0;
         held_l_ff <= '0;
         held_r_ff <= '0;
         bridge_ff <= 1'b0;
         led_ff    <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            loaded_ff <= loaded_in;
            ptr_ff    <= ptr_in;
            start_ff  <= start_in;
            ramp_l_ff <= ramp_l_in;
            ramp_r_ff <= ramp_r_in;
            run_ff    <= run_in;
            held_l_ff <= held_l_in;
            held_r_ff <= held_r_in;
            bridge_ff <= bridge_in;
            led_ff    <= led_in;
         end
      end
   end

   // A run keeps the bridge enabled and the ready LED dark
   a_run_bridge: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (bridge_ff && !led_ff))
      else $error("run active without bridge enabled");

   // The step pointer never exceeds the table depth
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) <= TABLE_DEPTH)
      else $error("step pointer beyond table");

   // An accepted word is worked on in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == msps_pkg::ST_EXEC))
      else $error("accepted word not executed");

   // A finishing result leaves the run stopped
   a_fin_stop: assert property (@(posedge clock) disable iff (reset)
      (commit && fin) |=> (!run_ff && led_ff && held_l_ff == 12'sd0))
      else $error("finish did not stop the run");

endmodule

[src/motor_step_profile_sequencer.sv]
// Motion step sequencer with slew-limited drive outputs.
// Request channel (req_valid/req_ready): one word per item. req_kind selects
// an update tick (carries req_now_ms), a step table write (req_step_index and
// the step fields) or a run start (req_step_count steps from entry 0, clamped
// to the table depth, timed from req_now_ms).
// Response channel (rsp_valid/rsp_ready): exactly one word per request word,
// in order, carrying the held drive values, bridge enable, ready LED, running
// and a one-word finished pulse; rsp_drive_valid marks words that changed
// the drives.
// The step table is read and the item captured at the accepting edge; the
// update is then computed and registered into the output register once that
// register can take it. No new request is taken while a word is being
// updated, but a new request is taken while the previous response still
// sits in the output register.
// Reset clears the run, zeroes the drives, drops the bridge enable and lights
// the LED; table contents are undefined until written.
// A stalled receiver holds the response register; the next word then waits
// in the update stage and no further request is taken.
module motor_step_profile_sequencer #(
   parameter int TABLE_DEPTH = msps_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_now_ms,
   input  logic [3:0]         req_step_index,
   input  logic [15:0]        req_step_time_ms,
   input  logic signed [11:0] req_step_left,
   input  logic signed [11:0] req_step_right,
   input  logic signed [11:0] req_step_accel,
   input  logic [15:0]        req_step_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_drive_valid,
   output logic signed [11:0] rsp_left_drive,
   output logic signed [11:0] rsp_right_drive,
   output logic               rsp_bridge_enable,
   output logic               rsp_ready_led,
   output logic               rsp_running,
   output logic               rsp_finished
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PW = $clog2(TABLE_DEPTH + 1);

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   msps_pkg::entry_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr_a;
   logic [AW-1:0]       rd_addr_b;
   msps_pkg::entry_type rd_data_a;
   msps_pkg::entry_type rd_data_b;

   logic                res_valid;
   logic                res_ready;
   msps_pkg::rsp_type   res;

   logic                rsp_valid_ff;
   msps_pkg::rsp_type   rsp_ff;

   msps_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   msps_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .PW          (PW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_now_ms       (req_now_ms),
      .req_step_index   (req_step_index),
      .req_step_time_ms (req_step_time_ms),
      .req_step_left    (req_step_left),
      .req_step_right   (req_step_right),
      .req_step_accel   (req_step_accel),
      .req_step_count   (req_step_count),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res),
      .tbl_wr_en        (wr_en),
      .tbl_wr_addr      (wr_addr),
      .tbl_wr_data      (wr_data),
      .tbl_rd_en        (rd_en),
      .tbl_rd_addr_a    (rd_addr_a),
      .tbl_rd_addr_b    (rd_addr_b),
      .tbl_rd_data_a    (rd_data_a),
      .tbl_rd_data_b    (rd_data_b)
   );

   // Output register takes a word when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_valid   = rsp_ff.drive_valid;
   assign rsp_left_drive    = rsp_ff.left_drive;
   assign rsp_right_drive   = rsp_ff.right_drive;
   assign rsp_bridge_enable = rsp_ff.bridge_enable;
   assign rsp_ready_led     = rsp_ff.ready_led;
   assign rsp_running       = rsp_ff.running;
   assign rsp_finished      = rsp_ff.finished;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int TBL_N = msps_pkg::TABLE_DEPTH_DEF;
   localparam int WORD_TARGET = 1650;

   // One request word as the sender sees it
   typedef struct {
      logic [1:0]         kind;
      logic [31:0]        now_ms;
      logic [3:0]         idx;
      logic [15:0]        dur;
      logic signed [11:0] left;
      logic signed [11:0] right;
      logic signed [11:0] accel;
      logic [15:0]        count;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic [31:0]        req_now_ms = '0;
   logic [3:0]         req_step_index = '0;
   logic [15:0]        req_step_time_ms = '0;
   logic signed [11:0] req_step_left = '0;
   logic signed [11:0] req_step_right = '0;
   logic signed [11:0] req_step_accel = '0;
   logic [15:0]        req_step_count = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_drive_valid;
   logic signed [11:0] rsp_left_drive;
   logic signed [11:0] rsp_right_drive;
   logic               rsp_bridge_enable;
   logic               rsp_ready_led;
   logic               rsp_running;
   logic               rsp_finished;

   motor_step_profile_sequencer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_now_ms        (req_now_ms),
      .req_step_index    (req_step_index),
      .req_step_time_ms  (req_step_time_ms),
      .req_step_left     (req_step_left),
      .req_step_right    (req_step_right),
      .req_step_accel    (req_step_accel),
      .req_step_count    (req_step_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_valid   (rsp_drive_valid),
      .rsp_left_drive    (rsp_left_drive),
      .rsp_right_drive   (rsp_right_drive),
      .rsp_bridge_enable (rsp_bridge_enable),
      .rsp_ready_led     (rsp_ready_led),
      .rsp_running       (rsp_running),
      .rsp_finished      (rsp_finished)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Words waiting to be sent and drive words still owed by the block
   req_word_type      pending_words[$];
   msps_pkg::rsp_type drive_words_due[$];
   req_word_type      cur_word;
   int                words_taken = 0;
   int                words_total = 0;
   int                fail_count = 0;
   int                words_seen = 0;
   logic              calm;

   // Idling stops for a long stretch in the middle of the run
   assign calm = (words_taken >= 700) && (words_taken < 1000);

   // ---------------------------------------------------------------
   // Profile predictor: its own copy of the table and run state
   // ---------------------------------------------------------------
   msps_pkg::entry_type prof_tbl [TBL_N];
   int                  prof_loaded = 0;
   int                  prof_ptr = 0;
   logic [31:0]         prof_t0 = '0;
   int                  ramp_l = 0;
   int                  ramp_r = 0;
   bit                  prof_run = 1'b0;
   int                  hold_l = 0;
   int                  hold_r = 0;
   bit                  hold_bridge = 1'b0;
   bit                  hold_led = 1'b1;

   // Move one drive toward its target by inc, never past it
   function automatic int step_toward(input int cur, input int target, input int inc);
      int res;
      res = cur;
      if (cur < target) begin
         res = cur + inc;
         if (res > target) res = target;
      end else if (cur > target) begin
         res = cur - inc;
         if (res < target) res = target;
      end
      return res;
   endfunction

   // Apply one accepted word to the profile state and form its drive word
   function automatic msps_pkg::rsp_type drive_after(input req_word_type w);
      msps_pkg::rsp_type   r;
      msps_pkg::entry_type e;
      int                  n;
      logic [31:0]         dur;
      bit                  upd;
      bit                  fin;
      upd = 1'b0;
      fin = 1'b0;
      case (w.kind)
         msps_pkg::KIND_WRITE: begin
            prof_tbl[w.idx].time_ms = w.dur;
            prof_tbl[w.idx].left    = w.left;
            prof_tbl[w.idx].right   = w.right;
            prof_tbl[w.idx].accel   = w.accel;
         end
         msps_pkg::KIND_START: begin
            n = (w.count > TBL_N) ? TBL_N : int'(w.count);
            prof_loaded = n;
            if (n > 0) begin
               hold_bridge = 1'b1;
               hold_led = 1'b0;
               prof_ptr = 0;
               prof_t0 = w.now_ms;
               prof_run = 1'b1;
               ramp_l = 0;
               ramp_r = 0;
               e = prof_tbl[0];
               if (e.accel <= 0) begin
                  hold_l = e.left;
                  hold_r = e.right;
               end else begin
                  hold_l = 0;
                  hold_r = 0;
               end
               upd = 1'b1;
            end
         end
         msps_pkg::KIND_TICK: begin
            if (prof_run) begin
               if (prof_ptr < prof_loaded) begin
                  e = prof_tbl[prof_ptr];
                  dur = (e.time_ms == 16'd0) ? 32'(msps_pkg::DEFAULT_STEP_MS)
                                             : 32'(e.time_ms);
                  // ramped step: slew both drives
                  if (e.accel > 0) begin
                     ramp_l = step_toward(ramp_l, e.left, e.accel);
                     ramp_r = step_toward(ramp_r, e.right, e.accel);
                     hold_l = ramp_l;
                     hold_r = ramp_r;
                     upd = 1'b1;
                  end
                  // step time used up: advance
                  if (32'(w.now_ms - prof_t0) >= dur) begin
                     prof_ptr++;
                     ramp_l = 0;
                     ramp_r = 0;
                     if (prof_ptr < prof_loaded) begin
                        e = prof_tbl[prof_ptr];
                        prof_t0 = w.now_ms;
                        if (e.accel <= 0) begin
                           hold_l = e.left;
                           hold_r = e.right;
                           upd = 1'b1;
                        end
                     end else begin
                        fin = 1'b1;
                     end
                  end
               end else begin
                  fin = 1'b1;
               end
            end
         end
         default: ;
      endcase
      // end of run: stop drives, drop bridge, light LED
      if (fin) begin
         hold_l = 0;
         hold_r = 0;
         hold_bridge = 1'b0;
         hold_led = 1'b1;
         prof_run = 1'b0;
         ramp_l = 0;
         ramp_r = 0;
         upd = 1'b1;
      end
      r.drive_valid   = upd;
      r.left_drive    = hold_l[11:0];
      r.right_drive   = hold_r[11:0];
      r.bridge_enable = hold_bridge;
      r.ready_led     = hold_led;
      r.running       = prof_run;
      r.finished      = fin;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus builder with a small shadow of run progress
   // ---------------------------------------------------------------
   logic [TBL_N-1:0] written = '0;
   int               gen_dur [TBL_N];
   int               gen_ptr = 0;
   int               gen_len = 0;
   logic [31:0]      gen_t0 = '0;
   bit               gen_done = 1'b1;
   int               counted = 0;

   function automatic req_word_type random_word();
      req_word_type w;
      w.kind   = 2'($urandom);
      w.now_ms = $urandom;
      w.idx    = 4'($urandom);
      w.dur    = 16'($urandom);
      w.left   = 12'($urandom);
      w.right  = 12'($urandom);
      w.accel  = 12'($urandom);
      w.count  = 16'($urandom);
      return w;
   endfunction

   task automatic push_word(input req_word_type w);
      pending_words.push_back(w);
      words_total++;
      if (w.kind != KIND_UNUSED) counted++;
   endtask

   task automatic push_write(input logic [3:0] idx, input logic [15:0] dur,
                             input logic signed [11:0] l, input logic signed [11:0] r,
                             input logic signed [11:0] a);
      req_word_type w;
      w = random_word();
      w.kind  = msps_pkg::KIND_WRITE;
      w.idx   = idx;
      w.dur   = dur;
      w.left  = l;
      w.right = r;
      w.accel = a;
      written[idx] = 1'b1;
      gen_dur[idx] = (dur == 16'd0) ? int'(msps_pkg::DEFAULT_STEP_MS) : int'(dur);
      push_word(w);
   endtask

   task automatic push_start(input logic [15:0] count, input logic [31:0] now);
      req_word_type w;
      w = random_word();
      w.kind   = msps_pkg::KIND_START;
      w.count  = count;
      w.now_ms = now;
      gen_len = (count > TBL_N) ? TBL_N : int'(count);
      if (count != 16'd0) begin
         gen_ptr = 0;
         gen_t0 = now;
         gen_done = 1'b0;
      end
      push_word(w);
   endtask

   task automatic push_tick(input logic [31:0] now);
      req_word_type w;
      w = random_word();
      w.kind   = msps_pkg::KIND_TICK;
      w.now_ms = now;
      // track where the run will be after this tick
      if (!gen_done) begin
         if (gen_ptr >= gen_len) begin
            gen_done = 1'b1;
         end else if (32'(now - gen_t0) >= 32'(gen_dur[gen_ptr])) begin
            gen_ptr++;
            gen_t0 = now;
            if (gen_ptr >= gen_len) gen_done = 1'b1;
         end
      end
      push_word(w);
   endtask

   task automatic push_random_entry(input logic [3:0] idx);
      logic [15:0]        dur;
      logic signed [11:0] a;
      case ($urandom_range(0, 15))
         0:       dur = 16'hFFFF;
         1, 2:    dur = 16'd0;
         default: dur = 16'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 5))
         0, 1:    a = -12'sd1 * 12'($urandom_range(0, 2048));
         2:       a = 12'($urandom_range(1, 2047));
         default: a = 12'($urandom_range(1, 300));
      endcase
      push_write(idx, dur, 12'($urandom), 12'($urandom), a);
   endtask

   // ---------------------------------------------------------------
   // Driver: send pending words, predict on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin : driver
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drive_words_due.push_back(drive_after(cur_word));
            words_taken <= words_taken + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 17)) begin
               w = pending_words.pop_front();
               cur_word = w;
               req_kind         <= w.kind;
               req_now_ms       <= w.now_ms;
               req_step_index   <= w.idx;
               req_step_time_ms <= w.dur;
               req_step_left    <= w.left;
               req_step_right   <= w.right;
               req_step_accel   <= w.accel;
               req_step_count   <= w.count;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: check each drive word against the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      msps_pkg::rsp_type got;
      msps_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_drive_valid, rsp_left_drive, rsp_right_drive, rsp_bridge_enable,
                   rsp_ready_led, rsp_running, rsp_finished};
            if (drive_words_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("drive word %0d arrived with nothing expected", words_seen);
            end else begin
               want = drive_words_due.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("drive word %0d mismatch: want dv=%0b l=%0d r=%0d br=%0b %s",
                              words_seen, want.drive_valid, want.left_drive,
                              want.right_drive, want.bridge_enable, "");
                     $display("   want led=%0b run=%0b fin=%0b",
                              want.ready_led, want.running, want.finished);
                     $display("   got dv=%0b l=%0d r=%0d br=%0b led=%0b run=%0b fin=%0b",
                              got.drive_valid, got.left_drive, got.right_drive,
                              got.bridge_enable, got.ready_led, got.running,
                              got.finished);
                  end
               end
            end
            words_seen++;
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 17);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      req_word_type w;
      logic [31:0]  sim_ms;
      logic [15:0]  run_count;
      int           i;
      int           n;
      int           prefix;

      // idle tick, unused kind, empty start before any entry exists
      push_tick(32'h0000_0000);
      w = '{KIND_UNUSED, '1, '1, '1, '1, '1, '1, '1};
      push_word(w);
      push_start(16'd0, 32'hFFFF_FFFF);

      // extreme entries: default time, full-scale targets, ramp and immediate
      push_write(4'd0, 16'd0, -12'sd2048, 12'sd2047, 12'sd0);
      push_write(4'd1, 16'hFFFF, 12'sd2047, -12'sd2048, 12'sd2047);
      push_write(4'd2, 16'd1, 12'sd5, -12'sd5, 12'sd3);
      push_write(4'd3, 16'd10, -12'sd1, 12'sd0, -12'sd2048);

      // run across the time wrap, into a ramped step, then clamp at target
      push_start(16'd4, 32'hFFFF_FFF0);
      push_tick(32'hFFFF_FFF5);
      push_tick(32'h0000_0022);
      push_tick(32'h0000_0023);
      push_tick(32'h0000_0023 + 32'd65535);
      push_tick(32'h0000_0023 + 32'd65535);
      push_tick(32'h0000_0023 + 32'd65535);
      push_tick(32'h0000_0024 + 32'd65535);

      // restart mid-run, then zero count mid-run finishes on the next tick
      push_start(16'd4, 32'h0001_1000);
      push_start(16'd0, $urandom);
      push_tick(32'h0001_1001);
      push_tick(32'h0001_1002);

      // random runs over well-formed tables with noise mixed in
      sim_ms = $urandom;
      while (counted < WORD_TARGET) begin
         n = $urandom_range(1, TBL_N);
         for (i = 0; i < n; i++)
            if (!written[i] || $urandom_range(0, 2) == 0) push_random_entry(4'(i));
         if ($urandom_range(0, 3) == 0) push_random_entry(4'($urandom_range(0, TBL_N - 1)));
         prefix = 0;
         while (prefix < TBL_N && written[prefix]) prefix++;
         if (prefix == TBL_N && $urandom_range(0, 4) == 0)
            run_count = 16'($urandom_range(TBL_N, 65535));
         else
            run_count = 16'($urandom_range(1, prefix));

         case ($urandom_range(0, 7))
            0, 1:    sim_ms = $urandom;
            2:       sim_ms = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
            default: ;
         endcase
         push_start(run_count, sim_ms);

         while (!gen_done) begin
            if ($urandom_range(0, 11) == 0) begin
               case ($urandom_range(0, 4))
                  0: begin
                     w = random_word();
                     w.kind = KIND_UNUSED;
                     push_word(w);
                  end
                  1: push_random_entry(4'($urandom_range(0, TBL_N - 1)));
                  2: push_tick(sim_ms - 32'($urandom_range(1, 5000)));
                  3: push_start(run_count, sim_ms);
                  default: push_start(16'd0, $urandom);
               endcase
            end
            case ($urandom_range(0, 9))
               0:       ;
               1:       sim_ms = sim_ms + 32'($urandom_range(51, 70000));
               default: sim_ms = sim_ms + 32'($urandom_range(1, 25));
            endcase
            push_tick(sim_ms);
         end

         // a few ticks while idle
         n = $urandom_range(0, 2);
         for (i = 0; i < n; i++) begin
            sim_ms = sim_ms + 32'($urandom_range(0, 40));
            push_tick(sim_ms);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: every word sent and every drive word back
      while (words_taken != words_total || drive_words_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0 && drive_words_due.size() == 0) begin
         $display("[motor_step_profile_sequencer] OK");
      end else begin
         $display("[motor_step_profile_sequencer] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("[motor_step_profile_sequencer] ERROR");
      $finish;
   end

endmodule
